// ===== rtl/pgdt_pkg.sv =====
package pgdt_pkg;

  localparam int TIME_BITS_DEF       = 48;
  localparam int GROUP_BYTE_BITS_DEF = 24;

  // Widths of the fixed fields.
  localparam int FIELD_TIME_W  = 48;
  localparam int FIELD_BYTES_W = 16;
  localparam int SIZE_DELTA_W  = 25;
  localparam int GROUP_SPAN_W  = 20;
  localparam int BURST_GAP_W   = 20;
  localparam int BURST_SPAN_W  = 24;
  localparam int OFFSET_LIM_W  = 27;
  localparam int APB_ADDR_W    = 4;
  localparam int APB_DATA_W    = 32;

  localparam int SIZE_MAX_OUT = 16777215;
  localparam int SIZE_MIN_OUT = -16777216;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_GROUP_SPAN = 2'd0;
  localparam logic [1:0] REG_BURST_GAP  = 2'd1;
  localparam logic [1:0] REG_BURST_SPAN = 2'd2;
  localparam logic [1:0] REG_OFFSET_LIM = 2'd3;

  localparam logic [GROUP_SPAN_W-1:0] GROUP_SPAN_RST = 20'd5000;
  localparam logic [BURST_GAP_W-1:0]  BURST_GAP_RST  = 20'd5000;
  localparam logic [BURST_SPAN_W-1:0] BURST_SPAN_RST = 24'd100000;
  localparam logic [OFFSET_LIM_W-1:0] OFFSET_LIM_RST = 27'd3000000;

  typedef enum logic [1:0] {
    OUTC_ACCEPT = 2'd0,
    OUTC_DROP   = 2'd1,
    OUTC_RESET  = 2'd2
  } outcome_e;

endpackage

// ===== rtl/packet_group_delta_tracker.sv =====
// An accepted item passes the input register, then the result register; the group
// state is updated at the same edge as the result is registered.
// Throughput: one item per cycle while the result channel is not stalled.
// Reset (rst_ni low, asynchronous) empties both registers and forgets the open and
// previous groups; the configuration registers return to their default values.
module packet_group_delta_tracker #(
  parameter int TIME_BITS       = pgdt_pkg::TIME_BITS_DEF,
  parameter int GROUP_BYTE_BITS = pgdt_pkg::GROUP_BYTE_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // input channel
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic [pgdt_pkg::FIELD_TIME_W-1:0]         send_us_i,
  input  logic [pgdt_pkg::FIELD_TIME_W-1:0]         arrive_us_i,
  input  logic [pgdt_pkg::FIELD_TIME_W-1:0]         local_us_i,
  input  logic [pgdt_pkg::FIELD_BYTES_W-1:0]        bytes_i,
  // result channel
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      delta_ok_o,
  output logic signed [pgdt_pkg::FIELD_TIME_W-1:0]  send_delta_us_o,
  output logic signed [pgdt_pkg::FIELD_TIME_W-1:0]  arrive_delta_us_o,
  output logic signed [pgdt_pkg::SIZE_DELTA_W-1:0]  size_delta_o,
  output logic [1:0]                                outcome_o,
  // configuration port
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [pgdt_pkg::APB_ADDR_W-1:0]           paddr,
  input  logic [pgdt_pkg::APB_DATA_W-1:0]           pwdata,
  output logic [pgdt_pkg::APB_DATA_W-1:0]           prdata,
  output logic                                      pready
);

  localparam int TW = TIME_BITS;
  localparam int BW = GROUP_BYTE_BITS;
  localparam int EW = (TW > pgdt_pkg::FIELD_TIME_W) ? TW : pgdt_pkg::FIELD_TIME_W;
  localparam int ZW = (BW + 1 > pgdt_pkg::SIZE_DELTA_W + 1) ? BW + 1
                                                            : pgdt_pkg::SIZE_DELTA_W + 1;
  localparam logic signed [ZW-1:0] ZMAX = ZW'(pgdt_pkg::SIZE_MAX_OUT);
  localparam logic signed [ZW-1:0] ZMIN = ZW'(pgdt_pkg::SIZE_MIN_OUT);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [pgdt_pkg::GROUP_SPAN_W-1:0] group_span_q;
  logic [pgdt_pkg::BURST_GAP_W-1:0]  burst_gap_q;
  logic [pgdt_pkg::BURST_SPAN_W-1:0] burst_span_q;
  logic [pgdt_pkg::OFFSET_LIM_W-1:0] offset_lim_q;
  logic                              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_span_q <= pgdt_pkg::GROUP_SPAN_RST;
      burst_gap_q  <= pgdt_pkg::BURST_GAP_RST;
      burst_span_q <= pgdt_pkg::BURST_SPAN_RST;
      offset_lim_q <= pgdt_pkg::OFFSET_LIM_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        pgdt_pkg::REG_GROUP_SPAN: group_span_q <= pwdata[pgdt_pkg::GROUP_SPAN_W-1:0];
        pgdt_pkg::REG_BURST_GAP:  burst_gap_q  <= pwdata[pgdt_pkg::BURST_GAP_W-1:0];
        pgdt_pkg::REG_BURST_SPAN: burst_span_q <= pwdata[pgdt_pkg::BURST_SPAN_W-1:0];
        pgdt_pkg::REG_OFFSET_LIM: offset_lim_q <= pwdata[pgdt_pkg::OFFSET_LIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pgdt_pkg::REG_GROUP_SPAN: prdata = pgdt_pkg::APB_DATA_W'(group_span_q);
      pgdt_pkg::REG_BURST_GAP:  prdata = pgdt_pkg::APB_DATA_W'(burst_gap_q);
      pgdt_pkg::REG_BURST_SPAN: prdata = pgdt_pkg::APB_DATA_W'(burst_span_q);
      pgdt_pkg::REG_OFFSET_LIM: prdata = pgdt_pkg::APB_DATA_W'(offset_lim_q);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic          s1_valid_q;
  logic [TW-1:0] s1_send_q, s1_arrive_q, s1_skew_q;
  logic [pgdt_pkg::FIELD_BYTES_W-1:0] s1_bytes_q;
  logic [TW-1:0] in_send, in_arrive, in_local;
  logic          out_free, fire, in_take;

  assign in_send   = TW'(EW'(send_us_i));
  assign in_arrive = TW'(EW'(arrive_us_i));
  assign in_local  = TW'(EW'(local_us_i));

  assign out_free   = !out_valid_o || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // The arrival-minus-system skew is all the offset test needs of the local clock.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_send_q   <= in_send;
      s1_arrive_q <= in_arrive;
      s1_skew_q   <= in_arrive - in_local;
      s1_bytes_q  <= bytes_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Group state
  // ---------------------------------------------------------------------------
  logic          open_valid_q, prev_valid_q;
  logic [TW-1:0] open_first_send_q, open_last_send_q, open_first_arrive_q;
  logic [TW-1:0] open_complete_q, open_skew_q;
  logic [BW-1:0] open_bytes_q;
  logic [TW-1:0] prev_last_send_q, prev_complete_q, prev_skew_q;
  logic [BW-1:0] prev_bytes_q;

  logic [TW-1:0] arr_d, snd_d, prop_d, span_d, grp_d, s_d, a_d, skew_d;
  logic          gap_ok, span_ok, in_burst, beyond, reorder, new_group;
  logic          offset_hit, delta_ok;
  logic [BW-1:0] bytes_base, bytes_next;
  logic [BW:0]   bytes_sum;
  logic signed [ZW-1:0] zdiff;
  logic signed [pgdt_pkg::SIZE_DELTA_W-1:0] zsat;
  pgdt_pkg::outcome_e outcome;

  always_comb begin
    arr_d  = s1_arrive_q - open_complete_q;
    snd_d  = s1_send_q - open_last_send_q;
    prop_d = arr_d - snd_d;
    span_d = s1_arrive_q - open_first_arrive_q;
    grp_d  = s1_send_q - open_first_send_q;

    // Differences are two's complement; a negative one is below any threshold.
    gap_ok   = arr_d[TW-1] || (arr_d < TW'(burst_gap_q));
    span_ok  = span_d[TW-1] || (span_d < TW'(burst_span_q));
    in_burst = (s1_send_q == open_last_send_q) || (prop_d[TW-1] && gap_ok && span_ok);
    beyond   = !grp_d[TW-1] && (grp_d > TW'(group_span_q));

    reorder   = open_valid_q && (s1_send_q < open_last_send_q);
    new_group = open_valid_q && !reorder && !in_burst && beyond;

    s_d    = open_last_send_q - prev_last_send_q;
    a_d    = open_complete_q - prev_complete_q;
    skew_d = open_skew_q - prev_skew_q;
    offset_hit = new_group && prev_valid_q && !skew_d[TW-1] &&
                 (skew_d >= TW'(offset_lim_q));
    delta_ok   = new_group && prev_valid_q && !offset_hit;

    zdiff = $signed(ZW'(open_bytes_q)) - $signed(ZW'(prev_bytes_q));
    if (zdiff > ZMAX) begin
      zsat = pgdt_pkg::SIZE_DELTA_W'(ZMAX);
    end else if (zdiff < ZMIN) begin
      zsat = pgdt_pkg::SIZE_DELTA_W'(ZMIN);
    end else begin
      zsat = pgdt_pkg::SIZE_DELTA_W'(zdiff);
    end

    bytes_base = (open_valid_q && !new_group) ? open_bytes_q : '0;
    bytes_sum  = (BW + 1)'(bytes_base) + (BW + 1)'(s1_bytes_q);
    bytes_next = bytes_sum[BW] ? '1 : bytes_sum[BW-1:0];

    if (reorder) begin
      outcome = pgdt_pkg::OUTC_DROP;
    end else if (offset_hit) begin
      outcome = pgdt_pkg::OUTC_RESET;
    end else begin
      outcome = pgdt_pkg::OUTC_ACCEPT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_valid_q <= 1'b0;
      prev_valid_q <= 1'b0;
    end else if (fire) begin
      if (offset_hit) begin
        open_valid_q <= 1'b0;
        prev_valid_q <= 1'b0;
      end else if (!reorder) begin
        open_valid_q <= 1'b1;
        if (new_group) begin
          prev_valid_q <= 1'b1;
        end
      end
    end
  end

  // Contents of a group are only read while its valid flag is set.
  always_ff @(posedge clk_i) begin
    if (fire && !reorder && !offset_hit) begin
      if (new_group) begin
        prev_last_send_q <= open_last_send_q;
        prev_complete_q  <= open_complete_q;
        prev_skew_q      <= open_skew_q;
        prev_bytes_q     <= open_bytes_q;
      end
      if (!open_valid_q || new_group) begin
        open_first_send_q   <= s1_send_q;
        open_last_send_q    <= s1_send_q;
        open_first_arrive_q <= s1_arrive_q;
      end else if (s1_send_q > open_last_send_q) begin
        open_last_send_q <= s1_send_q;
      end
      open_bytes_q    <= bytes_next;
      open_complete_q <= s1_arrive_q;
      open_skew_q     <= s1_skew_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      delta_ok_o <= delta_ok;
      outcome_o  <= outcome;
      if (delta_ok) begin
        send_delta_us_o   <= pgdt_pkg::FIELD_TIME_W'(EW'($signed(s_d)));
        arrive_delta_us_o <= pgdt_pkg::FIELD_TIME_W'(EW'($signed(a_d)));
        size_delta_o      <= zsat;
      end else begin
        send_delta_us_o   <= '0;
        arrive_delta_us_o <= '0;
        size_delta_o      <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/pgdt_checker.sv =====
module pgdt_checker (
  input logic                                      clk_i,
  input logic                                      rst_ni,
  input logic                                      out_valid_o,
  input logic                                      out_stall_i,
  input logic                                      delta_ok_o,
  input logic signed [pgdt_pkg::FIELD_TIME_W-1:0]  send_delta_us_o,
  input logic signed [pgdt_pkg::FIELD_TIME_W-1:0]  arrive_delta_us_o,
  input logic signed [pgdt_pkg::SIZE_DELTA_W-1:0]  size_delta_o,
  input logic [1:0]                                outcome_o
);

  // A stalled result stays offered.
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(delta_ok_o) && $stable(outcome_o) &&
      $stable(send_delta_us_o) && $stable(arrive_delta_us_o) && $stable(size_delta_o))
    else $error("stalled result changed");

  // Deltas are only reported for items that were accepted into a group.
  a_delta_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && delta_ok_o |-> outcome_o == pgdt_pkg::OUTC_ACCEPT)
    else $error("deltas reported on a dropped or reset item");

  a_delta_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !delta_ok_o |->
      send_delta_us_o == '0 && arrive_delta_us_o == '0 && size_delta_o == '0)
    else $error("deltas not zero without a closed group");

endmodule

bind packet_group_delta_tracker pgdt_checker u_pgdt_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pgdt_pkg::*;

  typedef logic [FIELD_TIME_W-1:0] tstamp_t;

  typedef struct {
    tstamp_t     send;
    tstamp_t     arrive;
    tstamp_t     sys;
    logic [15:0] bytes;
    bit          hold;
  } pkt_t;

  typedef struct packed {
    logic                           ok;
    logic signed [FIELD_TIME_W-1:0] send_delta;
    logic signed [FIELD_TIME_W-1:0] arrive_delta;
    logic signed [SIZE_DELTA_W-1:0] size_delta;
    outcome_e                       outcome;
  } result_t;

  localparam tstamp_t TS_MAX    = '1;
  localparam longint  BYTES_CAP = (longint'(1) << GROUP_BYTE_BITS_DEF) - 1;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  tstamp_t                        send_us_i = '0;
  tstamp_t                        arrive_us_i = '0;
  tstamp_t                        local_us_i = '0;
  logic [FIELD_BYTES_W-1:0]       bytes_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic                           delta_ok_o;
  logic signed [FIELD_TIME_W-1:0] send_delta_us_o;
  logic signed [FIELD_TIME_W-1:0] arrive_delta_us_o;
  logic signed [SIZE_DELTA_W-1:0] size_delta_o;
  logic [1:0]                     outcome_o;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]          paddr = '0;
  logic [APB_DATA_W-1:0]          pwdata = '0;
  logic [APB_DATA_W-1:0]          prdata;
  logic                           pready;

  packet_group_delta_tracker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .send_us_i         (send_us_i),
    .arrive_us_i       (arrive_us_i),
    .local_us_i        (local_us_i),
    .bytes_i           (bytes_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .delta_ok_o        (delta_ok_o),
    .send_delta_us_o   (send_delta_us_o),
    .arrive_delta_us_o (arrive_delta_us_o),
    .size_delta_o      (size_delta_o),
    .outcome_o         (outcome_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Configuration copy held by the predictor.
  longint cfg_span   = longint'(GROUP_SPAN_RST);
  longint cfg_gap    = longint'(BURST_GAP_RST);
  longint cfg_bspan  = longint'(BURST_SPAN_RST);
  longint cfg_offset = longint'(OFFSET_LIM_RST);

  // Open and previous group state of the predictor.
  bit          grp_open = 1'b0;
  tstamp_t     grp_first_send = '0;
  tstamp_t     grp_last_send = '0;
  tstamp_t     grp_first_arrive = '0;
  tstamp_t     grp_complete = '0;
  tstamp_t     grp_sys = '0;
  logic [23:0] grp_bytes = '0;
  bit          prev_ok = 1'b0;
  tstamp_t     prev_last_send = '0;
  tstamp_t     prev_complete = '0;
  tstamp_t     prev_sys = '0;
  logic [23:0] prev_bytes = '0;

  pkt_t    pending_q[$];
  result_t delta_q[$];
  pkt_t    nxt;
  result_t want;
  bit      in_taken = 1'b0;
  bit      calm = 1'b0;
  bit      failed = 1'b0;

  tstamp_t gen_send, gen_arrive, gen_sys;

  int n_in = 0;
  int n_results = 0;
  int n_deltas = 0;
  int n_drops = 0;
  int n_clears = 0;
  int n_settings = 1;

  function automatic longint sx(tstamp_t v);
    return longint'($signed(v));
  endfunction

  function automatic tstamp_t rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[FIELD_TIME_W-1:0];
  endfunction

  // Folds one packet into the group state and returns the result it causes.
  function automatic result_t fold_packet(tstamp_t s, tstamp_t a, tstamp_t l, logic [15:0] b);
    result_t r;
    tstamp_t arr_gap, send_gap, prop, age, span;
    tstamp_t d_send, d_arr, d_sys, drift;
    bit      burst, fresh;
    longint  z;
    r = '0;
    r.outcome = OUTC_ACCEPT;
    arr_gap = a - grp_complete;
    send_gap = s - grp_last_send;
    prop = arr_gap - send_gap;
    age = a - grp_first_arrive;
    span = s - grp_first_send;
    burst = (send_gap == '0) ||
            (sx(prop) < 0 && sx(arr_gap) < cfg_gap && sx(age) < cfg_bspan);
    fresh = !burst && (sx(span) > cfg_span);
    if (!grp_open) begin
      grp_first_send = s;
      grp_last_send = s;
      grp_first_arrive = a;
    end else if (s < grp_last_send) begin
      r.outcome = OUTC_DROP;
      return r;
    end else if (fresh) begin
      if (prev_ok) begin
        d_send = grp_last_send - prev_last_send;
        d_arr = grp_complete - prev_complete;
        d_sys = grp_sys - prev_sys;
        drift = d_arr - d_sys;
        if (sx(drift) >= cfg_offset) begin
          // The arrival clock ran away from the system clock: forget everything.
          grp_open = 1'b0;
          grp_first_send = '0;
          grp_last_send = '0;
          grp_first_arrive = '0;
          grp_complete = '0;
          grp_sys = '0;
          grp_bytes = '0;
          prev_ok = 1'b0;
          prev_last_send = '0;
          prev_complete = '0;
          prev_sys = '0;
          prev_bytes = '0;
          r.outcome = OUTC_RESET;
          return r;
        end
        z = longint'(grp_bytes) - longint'(prev_bytes);
        if (z > longint'(SIZE_MAX_OUT)) z = longint'(SIZE_MAX_OUT);
        if (z < longint'(SIZE_MIN_OUT)) z = longint'(SIZE_MIN_OUT);
        r.ok = 1'b1;
        r.send_delta = d_send;
        r.arrive_delta = d_arr;
        r.size_delta = z[SIZE_DELTA_W-1:0];
      end
      prev_ok = 1'b1;
      prev_last_send = grp_last_send;
      prev_complete = grp_complete;
      prev_sys = grp_sys;
      prev_bytes = grp_bytes;
      grp_first_send = s;
      grp_last_send = s;
      grp_first_arrive = a;
      grp_bytes = '0;
    end else if (s > grp_last_send) begin
      grp_last_send = s;
    end
    z = longint'(grp_bytes) + longint'(b);
    grp_bytes = (z > BYTES_CAP) ? '1 : z[23:0];
    grp_complete = a;
    grp_sys = l;
    grp_open = 1'b1;
    return r;
  endfunction

  task automatic check_field(string what, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      failed = 1'b1;
      $display("%0t: %s expected %0h, got %0h", $time, what, exp_v, act_v);
    end
  endtask

  task automatic queue_pkt(tstamp_t s, tstamp_t a, tstamp_t l, logic [15:0] b, bit hold);
    pkt_t p;
    p.send = s;
    p.arrive = a;
    p.sys = l;
    p.bytes = b;
    p.hold = hold;
    pending_q.push_back(p);
  endtask

  // Mostly well-formed traffic scaled to the current spans, with some late
  // packets, arrival clock jumps and unrelated noise mixed in.
  task automatic queue_stream(int count, int hold_at);
    int          pick, r;
    longint      sstep, astep;
    logic [15:0] b;
    tstamp_t     s;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 99);
      b = (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom);
      if (pick < 8) begin
        s = rand48() % (gen_send + 48'd1);
        queue_pkt(s, rand48(), rand48(), 16'($urandom), i == hold_at);
      end else if (pick < 14) begin
        astep = longint'($urandom_range(0, 3000));
        gen_arrive = gen_arrive + tstamp_t'(astep);
        gen_sys = gen_sys + tstamp_t'(astep);
        queue_pkt(gen_send - tstamp_t'($urandom_range(1, 5000)), gen_arrive, gen_sys, b,
                  i == hold_at);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) sstep = 0;
        else if (r < 60) sstep = longint'($urandom_range(1, 32'(cfg_span + 1)));
        else sstep = cfg_span + longint'($urandom_range(1, 32'(cfg_span + 20000)));
        r = $urandom_range(0, 99);
        if (r < 45) astep = longint'($urandom_range(0, 32'(cfg_gap)));
        else astep = longint'($urandom_range(0, 32'(3 * cfg_span + 30000)));
        gen_send = gen_send + tstamp_t'(sstep);
        gen_sys = tstamp_t'(longint'(gen_sys) + astep +
                            longint'($urandom_range(0, 200)) - 100);
        if (pick < 17) astep = astep + cfg_offset + longint'($urandom_range(0, 100000));
        gen_arrive = gen_arrive + tstamp_t'(astep);
        queue_pkt(gen_send, gen_arrive, gen_sys, b, i == hold_at);
      end
    end
  endtask

  task automatic apb_xfer(bit wr, logic [1:0] idx, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(logic [1:0] idx, longint value);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    check_field($sformatf("register %0d", idx), 64'(32'(value)), 64'(rd));
  endtask

  task automatic write_reg(logic [1:0] idx, longint value);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, 32'(value), rd);
    check_reg(idx, value);
    case (idx)
      REG_GROUP_SPAN: cfg_span = value;
      REG_BURST_GAP:  cfg_gap = value;
      REG_BURST_SPAN: cfg_bspan = value;
      REG_OFFSET_LIM: cfg_offset = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(longint span, longint gap, longint bspan, longint offset);
    write_reg(REG_GROUP_SPAN, span);
    write_reg(REG_BURST_GAP, gap);
    write_reg(REG_BURST_SPAN, bspan);
    write_reg(REG_OFFSET_LIM, offset);
    n_settings++;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_i || delta_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // Driver: presents the next item at the falling edge once the last one is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 26) &&
            !(pending_q[0].hold && delta_q.size() != 0)) begin
          nxt = pending_q.pop_front();
          send_us_i <= nxt.send;
          arrive_us_i <= nxt.arrive;
          local_us_i <= nxt.sys;
          bytes_i <= nxt.bytes;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 26);
    end
  end

  // Monitor: predicts on every accepted item and checks every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      delta_q.push_back(fold_packet(send_us_i, arrive_us_i, local_us_i, bytes_i));
      in_taken = 1'b1;
      n_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (delta_q.size() == 0) begin
        failed = 1'b1;
        $display("%0t: result arrived with no item waiting for it", $time);
      end else begin
        want = delta_q.pop_front();
        n_results++;
        check_field("delta_ok", 64'(want.ok), 64'(delta_ok_o));
        check_field("send_delta_us", 64'(want.send_delta), 64'(send_delta_us_o));
        check_field("arrive_delta_us", 64'(want.arrive_delta), 64'(arrive_delta_us_o));
        check_field("size_delta", 64'(want.size_delta), 64'(size_delta_o));
        check_field("outcome", 64'(want.outcome), 64'(outcome_o));
        if (want.ok) n_deltas++;
        if (want.outcome == OUTC_DROP) n_drops++;
        if (want.outcome == OUTC_RESET) n_clears++;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_reg(REG_GROUP_SPAN, longint'(GROUP_SPAN_RST));
    check_reg(REG_BURST_GAP, longint'(BURST_GAP_RST));
    check_reg(REG_BURST_SPAN, longint'(BURST_SPAN_RST));
    check_reg(REG_OFFSET_LIM, longint'(OFFSET_LIM_RST));

    // Directed part under the default spans.
    queue_pkt(48'd1000, 48'd2000, 48'd2000, 16'h0000, 1'b0);
    queue_pkt(48'd1000, 48'd2100, 48'd2100, 16'hFFFF, 1'b0);
    queue_pkt(48'd500, 48'd2150, 48'd2150, 16'd7, 1'b0);
    queue_pkt(48'd3000, 48'd2200, 48'd2200, 16'd100, 1'b0);
    queue_pkt(48'd20000, 48'd30000, 48'd30000, 16'd1500, 1'b0);
    queue_pkt(48'd40000, 48'd50000, 48'd50000, 16'd1200, 1'b0);
    // Exactly one span after the group start still belongs to the group.
    queue_pkt(48'd45000, 48'd4000000, 48'd50500, 16'd900, 1'b0);
    queue_pkt(48'd70000, 48'd4010000, 48'd60000, 16'd300, 1'b0);
    // Arrival times wrapping through zero.
    queue_pkt(48'd100000, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_F000, 16'd10, 1'b0);
    queue_pkt(48'd100000, 48'h100, 48'h100, 16'd20, 1'b0);
    queue_pkt(48'd103000, 48'h200, 48'h200, 16'd30, 1'b0);
    queue_pkt(48'd200000, 48'h40_0000, 48'h40_0000, 16'd40, 1'b0);
    queue_pkt(48'd300000, 48'h80_0000, 48'h80_0100, 16'd50, 1'b0);
    queue_pkt(48'd300000, rand48(), rand48(), 16'($urandom), 1'b0);
    queue_pkt(48'd1, TS_MAX, TS_MAX, 16'hFFFF, 1'b0);
    wait_idle();

    gen_send = 48'd1000000 + tstamp_t'($urandom);
    gen_arrive = rand48();
    gen_sys = rand48();

    program_regs(0, 0, 0, 0);
    queue_stream(60, -1);
    wait_idle();

    program_regs(1000000, 1000000, 10000000, 100000000);
    queue_stream(60, -1);
    wait_idle();

    // No idling on either side here; one item waits for the pipeline to drain.
    calm = 1'b1;
    program_regs(longint'($urandom_range(0, 1000000)), longint'($urandom_range(0, 1000000)),
                 longint'($urandom_range(0, 10000000)),
                 longint'($urandom_range(0, 100000000)));
    queue_stream(80, 40);
    wait_idle();
    calm = 1'b0;

    // A long burst of full-size packets at one send time drives the group
    // byte count into saturation.
    program_regs(5000, 5000, 100000, 3000000);
    for (int k = 0; k < 258; k++) begin
      gen_arrive = gen_arrive + tstamp_t'($urandom_range(0, 100));
      queue_pkt(gen_send, gen_arrive, gen_sys, 16'hFFFF, 1'b0);
    end
    queue_stream(30, -1);
    wait_idle();

    program_regs(longint'($urandom_range(0, 1000000)), longint'($urandom_range(0, 1000000)),
                 longint'($urandom_range(0, 10000000)),
                 longint'($urandom_range(0, 100000000)));
    queue_stream(50, -1);
    // Send times at the top of the range; nothing can follow these.
    queue_pkt(TS_MAX - 48'd3000000, gen_arrive + 48'd10, gen_sys + 48'd10, 16'hFFFF, 1'b0);
    queue_pkt(TS_MAX - 48'd1000000, gen_arrive + 48'd9000, gen_sys + 48'd9000, 16'd1, 1'b0);
    queue_pkt(TS_MAX - 48'd1, gen_arrive + 48'd40000, gen_sys + 48'd40000, 16'd2, 1'b0);
    queue_pkt(TS_MAX, gen_arrive + 48'd2000000, gen_sys + 48'd2000000, 16'd3, 1'b0);
    queue_pkt(TS_MAX, gen_arrive + 48'd2000100, gen_sys + 48'd2000100, 16'd4, 1'b0);
    queue_pkt('0, '0, '0, 16'd5, 1'b0);
    wait_idle();

    repeat (10) @(posedge clk_i);
    $display("Run covered %0d packets under %0d register settings, %0d results checked.",
             n_in, n_settings, n_results);
    $display("Of these, %0d closed groups with deltas, %0d reordered drops, %0d offset clears.",
             n_deltas, n_drops, n_clears);
    if (!failed && delta_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== packet_group_delta_tracker.f =====
rtl/pgdt_pkg.sv
rtl/packet_group_delta_tracker.sv
rtl/pgdt_checker.sv
bench/tb_top.sv
